/* rtl/two_operator_fm_voice_unit_defines.svh */
// assertion macros used by the voice unit checker
`ifndef TWO_OPERATOR_FM_VOICE_UNIT_DEFINES_SVH
`define TWO_OPERATOR_FM_VOICE_UNIT_DEFINES_SVH

// clocked assertion, quiet while reset is held
`define FMV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked assertion that also checks during reset
`define FMV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/fmv_pkg.sv */
package fmv_pkg;

  // field and register widths
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 40;
  localparam int unsigned RATIO_W     = 16;
  localparam int unsigned AMP_W       = 24;
  localparam int unsigned PSCALE_W    = 40;
  localparam int unsigned PSCALE_LO_W = 24;
  localparam int unsigned PSCALE_HI_W = PSCALE_W - PSCALE_LO_W;
  localparam int unsigned BASE_W      = 24;
  localparam int unsigned NOTE_W      = 7;
  localparam int unsigned NOTE_COUNT  = 128;
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned AMP_FRAC_W  = 23;

  // shared multiplier operand widths
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned MUL_W   = MUL_A_W + MUL_B_W;

  // register defaults
  localparam logic [RATIO_W-1:0]  MOD_INDEX_RST   = 16'd256;
  localparam logic [RATIO_W-1:0]  MOD_DEPTH_RST   = 16'd0;
  localparam logic [AMP_W-1:0]    AMP_STEP_RST    = 24'd84;
  localparam logic [AMP_W-1:0]    AMP_MAX_RST     = 24'd2097152;
  localparam logic [PSCALE_W-1:0] PHASE_SCALE_RST = 40'd5864062015;
  localparam int unsigned         NOTE_A4         = 69;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK     = 2'd0,
    ACT_NOTE_ON  = 2'd1,
    ACT_NOTE_OFF = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOD_INDEX   = 3'd0,
    CFG_MOD_DEPTH   = 3'd1,
    CFG_AMP_STEP    = 3'd2,
    CFG_AMP_MAX     = 3'd3,
    CFG_PHASE_SCALE = 3'd4,
    CFG_ALWAYS_ON   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [RATIO_W-1:0]  mod_index;
    logic [RATIO_W-1:0]  mod_depth;
    logic [AMP_W-1:0]    amp_step;
    logic [AMP_W-1:0]    amp_max;
    logic [PSCALE_W-1:0] phase_scale;
    logic                always_on;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEPTH,
    ST_MODOUT,
    ST_MODFREQ,
    ST_MINC_HI,
    ST_MINC_LO,
    ST_MINC_ADD,
    ST_CINC_LO,
    ST_CINC_ADD,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_DEPTH,
    OP_MODOUT,
    OP_MODFREQ,
    OP_MINC_HI,
    OP_MINC_LO,
    OP_MINC_ADD,
    OP_CINC_LO,
    OP_CINC_ADD,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // top octave (notes 120..131) in Q16.16
  localparam logic [31:0] TOP_OCTAVE [12] = '{
    32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
    32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
    32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353
  };

  typedef logic [BASE_W-1:0] note_tbl_t [NOTE_COUNT];

  // lower octaves by rounded right shift of the top octave
  function automatic note_tbl_t build_note_table();
    note_tbl_t   tbl;
    logic [63:0] k;
    logic [63:0] v;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      k = 64'd18 - 64'(i / 12);
      v = (64'(TOP_OCTAVE[i % 12]) + (64'd1 << (k - 64'd1))) >> k;
      tbl[i] = BASE_W'(v);
    end
    return tbl;
  endfunction

  localparam note_tbl_t NOTE_FREQ = build_note_table();

endpackage

/* rtl/fmv_cfg.sv */
module fmv_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fmv_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fmv_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output fmv_pkg::cfg_t                    cfg_o
);

  fmv_pkg::cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        fmv_pkg::CFG_MOD_INDEX:   cfg_d.mod_index   = cfg_data_i[fmv_pkg::RATIO_W-1:0];
        fmv_pkg::CFG_MOD_DEPTH:   cfg_d.mod_depth   = cfg_data_i[fmv_pkg::RATIO_W-1:0];
        fmv_pkg::CFG_AMP_STEP:    cfg_d.amp_step    = cfg_data_i[fmv_pkg::AMP_W-1:0];
        fmv_pkg::CFG_AMP_MAX:     cfg_d.amp_max     = cfg_data_i[fmv_pkg::AMP_W-1:0];
        fmv_pkg::CFG_PHASE_SCALE: cfg_d.phase_scale = cfg_data_i[fmv_pkg::PSCALE_W-1:0];
        fmv_pkg::CFG_ALWAYS_ON:   cfg_d.always_on   = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mod_index   <= fmv_pkg::MOD_INDEX_RST;
      cfg_q.mod_depth   <= fmv_pkg::MOD_DEPTH_RST;
      cfg_q.amp_step    <= fmv_pkg::AMP_STEP_RST;
      cfg_q.amp_max     <= fmv_pkg::AMP_MAX_RST;
      cfg_q.phase_scale <= fmv_pkg::PHASE_SCALE_RST;
      cfg_q.always_on   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/fmv_sine_rom.sv */
module fmv_sine_rom #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic [ADDR_W-1:0]        addr_i,
  output logic signed [WIDTH-1:0]  data_o
);

  typedef logic signed [WIDTH-1:0] sine_tbl_t [DEPTH];

  // quarter-wave polynomial in Q30, mirrored and negated per quadrant
  function automatic sine_tbl_t build_table();
    sine_tbl_t   t;
    logic [63:0] smp_max;
    logic [63:0] q30;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] y;
    logic [63:0] v;
    smp_max = (64'd1 << (WIDTH - 1)) - 64'd1;
    q30 = 64'd1 << 30;
    for (int i = 0; i < DEPTH; i++) begin
      p  = (64'(i) << 32) / DEPTH;
      q  = (p >> 30) & 64'd3;
      x  = p & (q30 - 64'd1);
      if (q[0]) x = q30 - x;
      x2 = (x * x) >> 30;
      y  = 64'd3864;
      y  = 64'd172272 - ((y * x2) >> 30);
      y  = 64'd5026995 - ((y * x2) >> 30);
      y  = 64'd85569306 - ((y * x2) >> 30);
      y  = 64'd693598668 - ((y * x2) >> 30);
      y  = 64'd1686629713 - ((y * x2) >> 30);
      y  = (y * x) >> 30;
      v  = (y * smp_max + (q30 >> 1)) >> 30;
      if (v > smp_max) v = smp_max;
      t[i] = q[1] ? WIDTH'(64'd0 - v) : WIDTH'(v);
    end
    return t;
  endfunction

  localparam sine_tbl_t SINE_LUT = build_table();

  // registered read
  always_ff @(posedge clk_i) begin
    data_o <= SINE_LUT[addr_i];
  end

endmodule

/* rtl/fmv_ctrl.sv */
module fmv_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic [fmv_pkg::ACTION_W-1:0]    action_i,
  input  fmv_pkg::sts_t                   sts_i,
  output logic                            in_ready_o,
  output fmv_pkg::cmd_t                   cmd_o
);

  fmv_pkg::state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fmv_pkg::ST_IDLE: begin
        if (in_valid_i && (action_i == fmv_pkg::ACT_TICK)) state_d = fmv_pkg::ST_DEPTH;
      end
      fmv_pkg::ST_DEPTH:    state_d = fmv_pkg::ST_MODOUT;
      fmv_pkg::ST_MODOUT:   state_d = fmv_pkg::ST_MODFREQ;
      fmv_pkg::ST_MODFREQ:  state_d = fmv_pkg::ST_MINC_HI;
      fmv_pkg::ST_MINC_HI:  state_d = fmv_pkg::ST_MINC_LO;
      fmv_pkg::ST_MINC_LO:  state_d = fmv_pkg::ST_MINC_ADD;
      fmv_pkg::ST_MINC_ADD: state_d = fmv_pkg::ST_CINC_LO;
      fmv_pkg::ST_CINC_LO:  state_d = fmv_pkg::ST_CINC_ADD;
      fmv_pkg::ST_CINC_ADD: state_d = fmv_pkg::ST_OUT;
      fmv_pkg::ST_OUT: begin
        if (sts_i.out_free) state_d = fmv_pkg::ST_IDLE;
      end
      default: state_d = fmv_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    in_ready_o = (state_q == fmv_pkg::ST_IDLE);
    cmd_o.op   = fmv_pkg::OP_NONE;
    case (state_q)
      fmv_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (action_i)
            fmv_pkg::ACT_NOTE_ON:  cmd_o.op = fmv_pkg::OP_NOTE_ON;
            fmv_pkg::ACT_NOTE_OFF: cmd_o.op = fmv_pkg::OP_NOTE_OFF;
            default:               cmd_o.op = fmv_pkg::OP_NONE;
          endcase
        end
      end
      fmv_pkg::ST_DEPTH:    cmd_o.op = fmv_pkg::OP_DEPTH;
      fmv_pkg::ST_MODOUT:   cmd_o.op = fmv_pkg::OP_MODOUT;
      fmv_pkg::ST_MODFREQ:  cmd_o.op = fmv_pkg::OP_MODFREQ;
      fmv_pkg::ST_MINC_HI:  cmd_o.op = fmv_pkg::OP_MINC_HI;
      fmv_pkg::ST_MINC_LO:  cmd_o.op = fmv_pkg::OP_MINC_LO;
      fmv_pkg::ST_MINC_ADD: cmd_o.op = fmv_pkg::OP_MINC_ADD;
      fmv_pkg::ST_CINC_LO:  cmd_o.op = fmv_pkg::OP_CINC_LO;
      fmv_pkg::ST_CINC_ADD: cmd_o.op = fmv_pkg::OP_CINC_ADD;
      fmv_pkg::ST_OUT: begin
        if (sts_i.out_free) cmd_o.op = fmv_pkg::OP_OUT;
      end
      default: cmd_o.op = fmv_pkg::OP_NONE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/fmv_dp.sv */
module fmv_dp #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  parameter int unsigned PHASE_WIDTH      = 32,
  parameter int unsigned SAMPLE_WIDTH     = 16,
  parameter int unsigned ADDR_W           = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fmv_pkg::cmd_t                    cmd_i,
  output fmv_pkg::sts_t                    sts_o,
  input  fmv_pkg::cfg_t                    cfg_i,
  input  logic [fmv_pkg::NOTE_W-1:0]       note_number_i,
  output logic [ADDR_W-1:0]                rom_addr_o,
  input  logic signed [SAMPLE_WIDTH-1:0]   rom_data_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0]   sample_out_o
);

  localparam int unsigned MUL_A_W    = fmv_pkg::MUL_A_W;
  localparam int unsigned MUL_B_W    = fmv_pkg::MUL_B_W;
  localparam int unsigned MUL_W      = fmv_pkg::MUL_W;
  localparam int unsigned AMP_W      = fmv_pkg::AMP_W;
  localparam int unsigned DEPTH_BITS = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned IDXP_W     = PHASE_WIDTH + DEPTH_BITS;
  localparam logic [IDXP_W-1:0] DEPTH_K = IDXP_W'(SINE_TABLE_DEPTH);
  localparam logic [MUL_W-1:0]  SMP_MAX =
    {{(MUL_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic [MUL_W-1:0]  SMP_NEG_MAX = SMP_MAX + MUL_W'(1);

  // voice state
  logic [PHASE_WIDTH-1:0]      mod_phase_q, mod_phase_d;
  logic [PHASE_WIDTH-1:0]      car_phase_q, car_phase_d;
  logic [AMP_W-1:0]            amp_q, amp_d;
  logic [AMP_W-1:0]            tgt_q, tgt_d;
  logic [fmv_pkg::BASE_W-1:0]  base_q, base_d;
  logic                        out_valid_q, out_valid_d;

  // working registers
  logic [MUL_W-1:0]            prod_q;
  logic [MUL_B_W-1:0]          mfreq_q;
  logic [PHASE_WIDTH-1:0]      acc_q;
  logic [MUL_A_W-1:0]          cmag_q;
  logic                        cneg_q;
  logic                        mneg_q;
  logic signed [SAMPLE_WIDTH-1:0] scar_q;
  logic [SAMPLE_WIDTH-1:0]     sample_q;

  logic [MUL_A_W-1:0]          mul_a;
  logic [MUL_B_W-1:0]          mul_b;
  logic                        mul_en;
  logic [PHASE_WIDTH-1:0]      rom_phase;
  logic [IDXP_W-1:0]           idx_prod;
  logic [SAMPLE_WIDTH-1:0]     rom_abs;
  logic [SAMPLE_WIDTH-1:0]     scar_abs;
  logic [MUL_B_W-1:0]          prod_q8;
  logic [MUL_W-1:0]            mm_full;
  logic [MUL_A_W-1:0]          base_ext;
  logic [MUL_A_W-1:0]          mmag_ext;
  logic [MUL_A_W-1:0]          cmag_d;
  logic                        cneg_d;
  logic [MUL_W-1:0]            lo_sh;
  logic [PHASE_WIDTH-1:0]      inc;
  logic [MUL_W-1:0]            smp_full;
  logic [MUL_W-1:0]            smp_sat;
  logic [SAMPLE_WIDTH-1:0]     smp_lo;
  logic [SAMPLE_WIDTH-1:0]     sample_d;
  logic [AMP_W-1:0]            amp_dn;
  logic [AMP_W:0]              amp_sum;
  logic [AMP_W-1:0]            amp_ramp;
  logic [fmv_pkg::PSCALE_HI_W-1:0] ps_hi;
  logic [fmv_pkg::PSCALE_LO_W-1:0] ps_lo;

  // sine table address from the selected phase
  assign rom_phase  = (cmd_i.op == fmv_pkg::OP_MODOUT) ? car_phase_q : mod_phase_q;
  assign idx_prod   = IDXP_W'(rom_phase) * DEPTH_K;
  assign rom_addr_o = idx_prod[PHASE_WIDTH +: ADDR_W];

  // magnitudes of sine values
  assign rom_abs  = rom_data_i[SAMPLE_WIDTH-1] ? (~rom_data_i + 1'b1) : rom_data_i;
  assign scar_abs = scar_q[SAMPLE_WIDTH-1] ? (~scar_q + 1'b1) : scar_q;

  // slices of the shared product
  assign prod_q8  = prod_q[fmv_pkg::FRAC_W +: MUL_B_W];
  assign mm_full  = prod_q >> (SAMPLE_WIDTH - 1);
  assign lo_sh    = prod_q >> fmv_pkg::PSCALE_LO_W;
  assign inc      = acc_q + lo_sh[PHASE_WIDTH-1:0];
  assign smp_full = prod_q >> fmv_pkg::AMP_FRAC_W;
  assign ps_hi    = cfg_i.phase_scale[fmv_pkg::PSCALE_W-1:fmv_pkg::PSCALE_LO_W];
  assign ps_lo    = cfg_i.phase_scale[fmv_pkg::PSCALE_LO_W-1:0];

  // carrier frequency as sign and magnitude
  assign base_ext = MUL_A_W'(base_q);
  assign mmag_ext = MUL_A_W'(mm_full[MUL_B_W-1:0]);
  always_comb begin
    if (!mneg_q) begin
      cneg_d = 1'b0;
      cmag_d = base_ext + mmag_ext;
    end else if (mmag_ext > base_ext) begin
      cneg_d = 1'b1;
      cmag_d = mmag_ext - base_ext;
    end else begin
      cneg_d = 1'b0;
      cmag_d = base_ext - mmag_ext;
    end
  end

  // sample saturation
  always_comb begin
    if (scar_q[SAMPLE_WIDTH-1]) begin
      smp_sat = (smp_full > SMP_NEG_MAX) ? SMP_NEG_MAX : smp_full;
    end else begin
      smp_sat = (smp_full > SMP_MAX) ? SMP_MAX : smp_full;
    end
    smp_lo   = smp_sat[SAMPLE_WIDTH-1:0];
    sample_d = scar_q[SAMPLE_WIDTH-1] ? (~smp_lo + 1'b1) : smp_lo;
  end

  // amplitude ramp: step down, then step up
  always_comb begin
    if (amp_q > tgt_q) begin
      amp_dn = (amp_q > cfg_i.amp_step) ? (amp_q - cfg_i.amp_step) : '0;
    end else begin
      amp_dn = amp_q;
    end
    amp_sum = {1'b0, amp_dn} + {1'b0, cfg_i.amp_step};
    if (amp_dn < tgt_q) begin
      amp_ramp = amp_sum[AMP_W] ? {AMP_W{1'b1}} : amp_sum[AMP_W-1:0];
    end else begin
      amp_ramp = amp_dn;
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    case (cmd_i.op)
      fmv_pkg::OP_DEPTH: begin
        mul_a  = base_ext;
        mul_b  = MUL_B_W'(cfg_i.mod_depth);
        mul_en = 1'b1;
      end
      fmv_pkg::OP_MODOUT: begin
        mul_a  = MUL_A_W'(rom_abs);
        mul_b  = prod_q8;
        mul_en = 1'b1;
      end
      fmv_pkg::OP_MODFREQ: begin
        mul_a  = base_ext;
        mul_b  = MUL_B_W'(cfg_i.mod_index);
        mul_en = 1'b1;
      end
      fmv_pkg::OP_MINC_HI: begin
        mul_a  = MUL_A_W'(prod_q8);
        mul_b  = MUL_B_W'(ps_hi);
        mul_en = 1'b1;
      end
      fmv_pkg::OP_MINC_LO: begin
        mul_a  = MUL_A_W'(mfreq_q);
        mul_b  = MUL_B_W'(ps_lo);
        mul_en = 1'b1;
      end
      fmv_pkg::OP_MINC_ADD: begin
        mul_a  = cmag_q;
        mul_b  = MUL_B_W'(ps_hi);
        mul_en = 1'b1;
      end
      fmv_pkg::OP_CINC_LO: begin
        mul_a  = cmag_q;
        mul_b  = MUL_B_W'(ps_lo);
        mul_en = 1'b1;
      end
      fmv_pkg::OP_CINC_ADD: begin
        mul_a  = MUL_A_W'(scar_abs);
        mul_b  = MUL_B_W'(amp_q);
        mul_en = 1'b1;
      end
      default: ;
    endcase
  end

  // voice state update
  always_comb begin
    mod_phase_d = mod_phase_q;
    car_phase_d = car_phase_q;
    amp_d       = amp_q;
    tgt_d       = tgt_q;
    base_d      = base_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (cmd_i.op)
      fmv_pkg::OP_NOTE_ON: begin
        tgt_d  = cfg_i.amp_max;
        base_d = fmv_pkg::NOTE_FREQ[note_number_i];
      end
      fmv_pkg::OP_NOTE_OFF: tgt_d = '0;
      fmv_pkg::OP_DEPTH: begin
        if (cfg_i.always_on) amp_d = cfg_i.amp_max;
      end
      fmv_pkg::OP_MINC_ADD: mod_phase_d = mod_phase_q + inc;
      fmv_pkg::OP_CINC_ADD: begin
        car_phase_d = cneg_q ? (car_phase_q - inc) : (car_phase_q + inc);
      end
      fmv_pkg::OP_OUT: begin
        out_valid_d = 1'b1;
        if (!cfg_i.always_on) amp_d = amp_ramp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_phase_q <= '0;
      car_phase_q <= '0;
      amp_q       <= '0;
      tgt_q       <= '0;
      base_q      <= fmv_pkg::NOTE_FREQ[fmv_pkg::NOTE_A4];
      out_valid_q <= 1'b0;
    end else begin
      mod_phase_q <= mod_phase_d;
      car_phase_q <= car_phase_d;
      amp_q       <= amp_d;
      tgt_q       <= tgt_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
    end
  end

  // shared multiplier and per-step captures
  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      fmv_pkg::OP_MODOUT: mneg_q <= rom_data_i[SAMPLE_WIDTH-1];
      fmv_pkg::OP_MODFREQ: begin
        scar_q <= rom_data_i;
        cmag_q <= cmag_d;
        cneg_q <= cneg_d;
      end
      fmv_pkg::OP_MINC_HI: mfreq_q  <= prod_q8;
      fmv_pkg::OP_MINC_LO: acc_q    <= prod_q[PHASE_WIDTH-1:0];
      fmv_pkg::OP_CINC_LO: acc_q    <= prod_q[PHASE_WIDTH-1:0];
      fmv_pkg::OP_OUT:     sample_q <= sample_d;
      default: ;
    endcase
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = sample_q;

endmodule

/* rtl/two_operator_fm_voice_unit.sv */
// Two-operator FM voice: one modulator, one carrier, linear amplitude ramp.
// Input channel (in_valid_i / in_ready_o) carries action_i and note_number_i:
// a tick computes one sample, a note on loads the base frequency from the note
// table and the amp_max target, a note off sets the target to zero. Code 3 is
// dropped. Note on and note off are taken while idle and give no sample.
// A tick runs through nine steps on one shared 33x32 multiplier plus two reads
// of the registered sine table; its sample is written to the output register
// in the last step, and the input stays closed until the sequence returns to
// idle, so a new tick is not accepted while one is still being computed.
// The sample sits in an output register until out_valid_o/out_ready_i
// transfer it; a following tick is accepted and computed meanwhile and holds
// in its last step until that register is free.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at the
// clock edge; unknown indexes are ignored.
// Reset (rst_ni low, asynchronous) clears both phases, amplitude and target,
// sets the base frequency to 440 Hz and the registers to their defaults.
module two_operator_fm_voice_unit #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  parameter int unsigned PHASE_WIDTH      = 32,
  parameter int unsigned SAMPLE_WIDTH     = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fmv_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fmv_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [fmv_pkg::ACTION_W-1:0]     action_i,
  input  logic [fmv_pkg::NOTE_W-1:0]       note_number_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]   sample_out_o
);

  localparam int unsigned ADDR_W = $clog2(SINE_TABLE_DEPTH);

  fmv_pkg::cfg_t                  cfg;
  fmv_pkg::cmd_t                  cmd;
  fmv_pkg::sts_t                  sts;
  logic [ADDR_W-1:0]              rom_addr;
  logic signed [SAMPLE_WIDTH-1:0] rom_data;

  // configuration registers
  fmv_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // step sequencer
  fmv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // sine table
  fmv_sine_rom #(
    .DEPTH  (SINE_TABLE_DEPTH),
    .WIDTH  (SAMPLE_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // arithmetic and voice state
  fmv_dp #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .PHASE_WIDTH      (PHASE_WIDTH),
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .ADDR_W           (ADDR_W)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_i         (cfg),
    .note_number_i (note_number_i),
    .rom_addr_o    (rom_addr),
    .rom_data_i    (rom_data),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .sample_out_o  (sample_out_o)
  );

endmodule

/* rtl/fmv_chk.sv */
`include "two_operator_fm_voice_unit_defines.svh"

module fmv_chk #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic [fmv_pkg::ACTION_W-1:0]     action_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0]   sample_out_o
);

  logic in_xfer;
  logic tick_xfer;
  logic out_stall;

  // handshake terms
  assign in_xfer   = in_valid_i && in_ready_o;
  assign tick_xfer = in_xfer && (action_i == fmv_pkg::ACT_TICK);
  assign out_stall = out_valid_o && !out_ready_i;

  // a stalled sample stays put
  `FMV_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(sample_out_o), "sample changed")

  // a tick keeps the input closed on the next cycle
  `FMV_ASSERT(a_tick_busy, tick_xfer |=> !in_ready_o, "input open right after a tick")

  // note and unused actions leave the input open on the next cycle
  `FMV_ASSERT(a_note_fast, in_xfer && !tick_xfer |=> in_ready_o, "input closed after a note")

  // a new sample only appears while a tick is in progress
  `FMV_ASSERT(a_out_from_tick, $rose(out_valid_o) |-> $past(!in_ready_o), "sample without a tick")

  // reset empties the output and opens the input
  `FMV_ASSERT_ALWAYS(a_reset_state, !rst_ni |-> !out_valid_o && in_ready_o, "bad reset state")

endmodule

bind two_operator_fm_voice_unit fmv_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_fmv_chk (.*);
